### rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel colorizer package
// Shared widths, register indexes and pixel classes of the colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

  localparam int unsigned PIX_W     = 16;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned RECIP_W   = 33;
  localparam int unsigned CFG_DATA_W = 33;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CH_W-1:0] CH_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_MODE  = 2'd0,
    REG_LOW_BOUND   = 2'd1,
    REG_HIGH_BOUND  = 2'd2,
    REG_RANGE_RECIP = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    KIND_BLACK,
    KIND_WHITE,
    KIND_RED,
    KIND_MAGENTA,
    KIND_GRAY,
    KIND_RAMP,
    KIND_SEG_RISE_G,
    KIND_SEG_FALL_R,
    KIND_SEG_RISE_B,
    KIND_SEG_FALL_G,
    KIND_SEG_RISE_R
  } kind_e;

endpackage

`default_nettype wire

### rtl/depth_pixel_colorizer_top.sv
// ----------------------------------------------------------------------------
// Depth pixel colorizer
// Maps one depth or amplitude sample to an RGB888 pixel, grayscale or
// five-segment rainbow, in a five-stage pipeline that takes one request per
// clock unless an output stall has backed it up; the 16 x 33 weight multiplier
// in the second stage sets the clock. Stages advance on their own, so bubbles
// collapse and a stall at the output backs up only as far as the pipeline is
// full. Configuration is written through a plain write port and is read live
// by the first two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_colorizer_top
  import dpc_pkg::*;
#(
  parameter int unsigned PIXEL_BITS       = 16,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_wr_en_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_value_i,

  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [CH_W-1:0]       red_o,
  output      logic [CH_W-1:0]       green_o,
  output      logic [CH_W-1:0]       blue_o
);

  localparam int unsigned NS     = 5;
  localparam int unsigned F      = WEIGHT_FRAC_BITS;
  localparam int unsigned PROD_W = PIXEL_BITS + RECIP_W;
  localparam int unsigned WW     = PIXEL_BITS + 1 + F;
  localparam int unsigned SHIFT  = 32 - F;
  localparam int unsigned FIVE_W = WW + 3;
  localparam int unsigned GRAY_W = WW + 8;
  localparam int unsigned RAMP_W = F + 1 + CH_W;

  localparam longint unsigned ONE_L = 64'd1 << F;
  localparam logic [F:0]    ONE = (F+1)'(ONE_L);
  localparam logic [WW-1:0] B1  = WW'((2 * 1 * ONE_L + 5) / 10);
  localparam logic [WW-1:0] B2  = WW'((2 * 2 * ONE_L + 5) / 10);
  localparam logic [WW-1:0] B3  = WW'((2 * 3 * ONE_L + 5) / 10);
  localparam logic [WW-1:0] B4  = WW'((2 * 4 * ONE_L + 5) / 10);

  // Configuration registers
  logic                color_mode_q;
  logic [PIX_W-1:0]    low_bound_q;
  logic [PIX_W-1:0]    high_bound_q;
  logic [RECIP_W-1:0]  range_recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= 1'b1;
      low_bound_q   <= '0;
      high_bound_q  <= PIX_W'(7500);
      range_recip_q <= RECIP_W'(572662);
    end else if (cfg_wr_en_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_COLOR_MODE:  color_mode_q  <= cfg_data_i[0];
        REG_LOW_BOUND:   low_bound_q   <= cfg_data_i[PIX_W-1:0];
        REG_HIGH_BOUND:  high_bound_q  <= cfg_data_i[PIX_W-1:0];
        REG_RANGE_RECIP: range_recip_q <= cfg_data_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic [NS-1:0] valid_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = valid_q[NS-1];

  // Stage 0: classify against the window
  logic [PIX_W-1:0]      pix;
  logic                  below;
  logic                  above;
  kind_e                 kind0_d, kind0_q;
  logic [PIXEL_BITS-1:0] diff0_d, diff0_q;

  always_comb begin
    pix     = PIX_W'(pixel_value_i[PIXEL_BITS-1:0]);
    below   = pix < low_bound_q;
    above   = pix > high_bound_q;
    diff0_d = (below || above) ? '0 : PIXEL_BITS'(pix - low_bound_q);
    if (!color_mode_q) begin
      if (below) begin
        kind0_d = KIND_BLACK;
      end else if (above) begin
        kind0_d = KIND_WHITE;
      end else begin
        kind0_d = KIND_GRAY;
      end
    end else if (pix == '0) begin
      kind0_d = KIND_BLACK;
    end else if (below) begin
      kind0_d = KIND_RED;
    end else if (above) begin
      kind0_d = KIND_MAGENTA;
    end else begin
      kind0_d = KIND_RAMP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      kind0_q <= kind0_d;
      diff0_q <= diff0_d;
    end
  end

  // Stage 1: weight multiply
  logic [PROD_W-1:0] prod;
  kind_e             kind1_q;
  logic [WW-1:0]     w1_q;

  assign prod = PROD_W'(diff0_q) * PROD_W'(range_recip_q);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      kind1_q <= kind0_q;
      w1_q    <= prod[PROD_W-1:SHIFT];
    end
  end

  // Stage 2: segment select and gray level
  kind_e               kind2_d, kind2_q;
  logic [WW-1:0]       base;
  logic [WW-1:0]       x2_d, x2_q;
  logic [GRAY_W-1:0]   gray_full;
  logic [GRAY_W-F-1:0] gray_int;
  logic [CH_W-1:0]     gray2_d, gray2_q;

  always_comb begin
    kind2_d = kind1_q;
    base    = '0;
    if (kind1_q == KIND_RAMP) begin
      if (w1_q > B4) begin
        kind2_d = KIND_SEG_RISE_R;
        base    = B4;
      end else if (w1_q > B3) begin
        kind2_d = KIND_SEG_FALL_G;
        base    = B3;
      end else if (w1_q > B2) begin
        kind2_d = KIND_SEG_RISE_B;
        base    = B2;
      end else if (w1_q > B1) begin
        kind2_d = KIND_SEG_FALL_R;
        base    = B1;
      end else begin
        kind2_d = KIND_SEG_RISE_G;
      end
    end
    x2_d      = w1_q - base;
    gray_full = {w1_q, 8'b0} - GRAY_W'(w1_q);
    gray_int  = gray_full[GRAY_W-1:F];
    gray2_d   = (gray_int > (GRAY_W-F)'(CH_MAX)) ? CH_MAX : gray_int[CH_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      kind2_q <= kind2_d;
      x2_q    <= x2_d;
      gray2_q <= gray2_d;
    end
  end

  // Stage 3: fraction within the segment
  logic [FIVE_W-1:0] x5;
  logic [F:0]        frac3_d, frac3_q;
  kind_e             kind3_q;
  logic [CH_W-1:0]   gray3_q;

  always_comb begin
    x5      = FIVE_W'({x2_q, 2'b0}) + FIVE_W'(x2_q);
    frac3_d = (x5 > FIVE_W'(ONE)) ? ONE : x5[F:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      kind3_q <= kind2_q;
      frac3_q <= frac3_d;
      gray3_q <= gray2_q;
    end
  end

  // Stage 4: ramps and output mux
  logic [F:0]      frac_inv;
  logic [RAMP_W-1:0] up_full;
  logic [RAMP_W-1:0] down_full;
  logic [CH_W-1:0] ramp_up;
  logic [CH_W-1:0] ramp_down;
  logic [CH_W-1:0] red_d, green_d, blue_d;
  logic [CH_W-1:0] red_q, green_q, blue_q;

  always_comb begin
    frac_inv  = ONE - frac3_q;
    up_full   = {frac3_q, 8'b0} - RAMP_W'(frac3_q);
    down_full = {frac_inv, 8'b0} - RAMP_W'(frac_inv);
    ramp_up   = up_full[F+CH_W-1:F];
    ramp_down = down_full[F+CH_W-1:F];
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    case (kind3_q)
      KIND_WHITE: begin
        red_d   = CH_MAX;
        green_d = CH_MAX;
        blue_d  = CH_MAX;
      end
      KIND_RED: begin
        red_d = CH_MAX;
      end
      KIND_MAGENTA: begin
        red_d  = CH_MAX;
        blue_d = CH_MAX;
      end
      KIND_GRAY: begin
        red_d   = gray3_q;
        green_d = gray3_q;
        blue_d  = gray3_q;
      end
      KIND_SEG_RISE_G: begin
        red_d   = CH_MAX;
        green_d = ramp_up;
      end
      KIND_SEG_FALL_R: begin
        red_d   = ramp_down;
        green_d = CH_MAX;
      end
      KIND_SEG_RISE_B: begin
        green_d = CH_MAX;
        blue_d  = ramp_up;
      end
      KIND_SEG_FALL_G: begin
        green_d = ramp_down;
        blue_d  = CH_MAX;
      end
      KIND_SEG_RISE_R: begin
        red_d  = ramp_up;
        blue_d = CH_MAX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[0])
    else $error("accepted request did not enter the pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !rdy[1] |=> valid_q[0])
    else $error("stalled request dropped from the first stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && out_stall_i |-> in_stall_o)
    else $error("full pipeline accepted a request under output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> frac3_q <= ONE)
    else $error("segment fraction exceeds one");
`endif

endmodule

`default_nettype wire
